// ----- rtl/rpdt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpdt_pkg
// Shared types and constants for the radio packet de-duplication table.
// ----------------------------------------------------------------------------
package rpdt_pkg;

	// Table geometry
	localparam int ENTRIES = 6;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	// Field widths
	localparam int ID_W     = 8;
	localparam int SERIAL_W = 32;
	localparam int KEY_W    = 8;
	localparam int COUNT_W  = 8;
	localparam int TIME_W   = 32;
	localparam int EXPIRY_W = 16;
	localparam int FACTOR_W = 4;
	localparam int EXP_W    = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Constants
	localparam logic [ID_W-1:0]     RETIRED_ID   = 8'd254;
	localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 16'd500;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 4'd3;
	localparam logic [EXP_W-1:0]    EXP_MAX      = 3'd7;

	// Command codes
	localparam logic CMD_PACKET = 1'b0;
	localparam logic CMD_SWEEP  = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXPIRY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd1;

	// One table entry
	typedef struct packed {
		logic [ID_W-1:0]     last_id;
		logic [SERIAL_W-1:0] serial;
		logic [KEY_W-1:0]    key;
		logic [COUNT_W-1:0]  count;
		logic [TIME_W-1:0]   born_ms;
	} entry_t;

	// Memory access request
	typedef struct packed {
		logic            we;
		logic [IDX_W-1:0] waddr;
		logic            re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/rpdt_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpdt_mem
// Entry store: one write port, one registered read port, and a valid bit per
// entry so that entries never written read back as all zero.
// ----------------------------------------------------------------------------
module rpdt_mem
	import rpdt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mem_req_t req,
	input  wire entry_t   wdata,
	output entry_t        rdata
);

	entry_t             mem_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	entry_t             rd_data_q;
	logic               rd_valid_q;

	// Write entry storage
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= wdata;
		end
	end

	// Mark written entries valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.we) begin
			valid_q[req.waddr] <= 1'b1;
		end
	end

	// Register read data
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data_q  <= mem_q[req.raddr];
			rd_valid_q <= valid_q[req.raddr];
		end
	end

	// Unwritten entries read as zero
	assign rdata = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ----- rtl/radio_packet_dedup_table_unit.sv -----
`default_nettype none
// Each command scans the entry memory, one entry per cycle through its single
// read port, then passes a drain and a finish state; the result strobe follows
// the finish state. busy blocks new commands until then; start may be taken in
// the cycle the result is shown.
// Reset: asynchronous; registers return to 500 ms and factor 3, all entries
// read as zero. The receiver cannot stall; the result strobe is high for one cycle.
// ----------------------------------------------------------------------------
// radio_packet_dedup_table_unit
// Packet de-duplication table: matches packets on serial and key, starts new
// series or counts repeats, and retires stale series on a sweep command.
// ----------------------------------------------------------------------------
module radio_packet_dedup_table_unit
	import rpdt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  cmd,
	input  wire logic [TIME_W-1:0]     now_ms,
	input  wire logic [ID_W-1:0]       packet_id,
	input  wire logic [SERIAL_W-1:0]   sender_serial,
	input  wire logic [KEY_W-1:0]      key_code,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       done,
	output logic [KEY_W-1:0]           key_out,
	output logic                       loss_detected,
	output logic [EXP_W-1:0]           expired_count
);

	state_t state_q, state_d;

	logic [EXPIRY_W-1:0] expiry_q;
	logic [FACTOR_W-1:0] factor_q;

	logic                cmd_q;
	logic [TIME_W-1:0]   now_q;
	logic [ID_W-1:0]     id_q;
	logic [SERIAL_W-1:0] serial_q;
	logic [KEY_W-1:0]    key_q;

	logic [IDX_W-1:0]    rd_addr_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;

	logic                hit_found_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [ID_W-1:0]     hit_id_q;
	logic [COUNT_W-1:0]  hit_cnt_q;
	logic [TIME_W-1:0]   hit_time_q;
	logic [IDX_W-1:0]    old_idx_q;
	logic [TIME_W-1:0]   old_time_q;

	logic                loss_q;
	logic [EXP_W-1:0]    exp_q;
	logic [KEY_W-1:0]    key_out_q;
	logic                done_q;

	logic                accept;
	logic                scan_rd;
	logic                finish;
	mem_req_t            req;
	entry_t              wdata;
	entry_t              rdata;

	logic                ent_match;
	logic                ent_older;
	logic                ent_active;
	logic [TIME_W-1:0]   ent_age;
	logic                ent_retire;
	logic [11:0]         ent_prod;
	logic [ID_W:0]       ent_need;
	logic                ent_loss;
	logic                new_series;
	logic                sweep_wr;

	assign accept = start && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expiry_q <= EXPIRY_RESET;
			factor_q <= FACTOR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXPIRY: expiry_q <= cfg_data;
				REG_FACTOR: factor_q <= cfg_data[FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture command on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			now_q    <= now_ms;
			id_q     <= packet_id;
			serial_q <= sender_serial;
			key_q    <= key_code;
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_SCAN;
			ST_SCAN:   if (rd_addr_q == LAST_IDX) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		busy    = 1'b1;
		scan_rd = 1'b0;
		finish  = 1'b0;
		case (state_q)
			ST_IDLE:   busy    = 1'b0;
			ST_SCAN:   scan_rd = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: finish  = 1'b1;
			default:   busy    = 1'b1;
		endcase
	end

	// Advance read address; track which entry the read data belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_rd;
			if (accept) begin
				rd_addr_q <= '0;
			end else if (scan_rd) begin
				rd_addr_q <= rd_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr_q;
	end

	// Examine the entry just read
	assign ent_match  = (rdata.serial == serial_q) && (rdata.key == key_q);
	assign ent_older  = (rd_idx_s1 == '0) || (old_time_q > rdata.born_ms);
	assign ent_active = (rdata.last_id != RETIRED_ID) && (rdata.count != '0);
	assign ent_age    = now_q - rdata.born_ms;
	assign ent_retire = ent_active && (ent_age > {{(TIME_W-EXPIRY_W){1'b0}}, expiry_q});
	assign ent_prod   = {8'b0, factor_q} * {4'b0, rdata.count};
	assign ent_need   = {1'b0, rdata.last_id} + 9'd1;
	assign ent_loss   = ent_prod < {3'b0, ent_need};
	assign sweep_wr   = rd_vld_s1 && (cmd_q == CMD_SWEEP) && ent_retire;

	// Hold best candidates during a packet scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q <= 1'b0;
		end else if (accept) begin
			hit_found_q <= 1'b0;
		end else if (rd_vld_s1 && (cmd_q == CMD_PACKET) && ent_match) begin
			hit_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && (cmd_q == CMD_PACKET)) begin
			if (ent_match && !hit_found_q) begin
				hit_idx_q  <= rd_idx_s1;
				hit_id_q   <= rdata.last_id;
				hit_cnt_q  <= rdata.count;
				hit_time_q <= rdata.born_ms;
			end
			if (ent_older) begin
				old_idx_q  <= rd_idx_s1;
				old_time_q <= rdata.born_ms;
			end
		end
	end

	// Accumulate sweep results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_q <= 1'b0;
			exp_q  <= '0;
		end else if (accept) begin
			loss_q <= 1'b0;
			exp_q  <= '0;
		end else if (sweep_wr) begin
			if (ent_loss) loss_q <= 1'b1;
			if (exp_q != EXP_MAX) exp_q <= exp_q + 1'b1;
		end
	end

	// Decide write-back at the end of a packet scan
	assign new_series = !hit_found_q || (id_q < hit_id_q);

	always_comb begin
		req.re    = scan_rd;
		req.raddr = rd_addr_q;
		req.we    = 1'b0;
		req.waddr = rd_idx_s1;
		wdata     = rdata;
		if (sweep_wr) begin
			req.we        = 1'b1;
			wdata.last_id = RETIRED_ID;
		end else if (finish && (cmd_q == CMD_PACKET)) begin
			req.we           = 1'b1;
			req.waddr        = hit_found_q ? hit_idx_q : old_idx_q;
			wdata.last_id    = id_q;
			wdata.serial     = serial_q;
			wdata.key        = key_q;
			wdata.count      = new_series ? COUNT_W'(1) : hit_cnt_q + 1'b1;
			wdata.born_ms    = new_series ? now_q : hit_time_q;
		end
	end

	rpdt_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.wdata  (wdata),
		.rdata  (rdata)
	);

	// Result strobe and key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			key_out_q <= '0;
		end else begin
			done_q <= finish;
			if (finish) begin
				key_out_q <= ((cmd_q == CMD_PACKET) && new_series) ? key_q : '0;
			end
		end
	end

	assign done          = done_q;
	assign key_out       = key_out_q;
	assign loss_detected = loss_q;
	assign expired_count = exp_q;

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FINISH)) else $error("result without finish");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !req.we) else $error("memory write while idle");
	a_packet_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (cmd_q == CMD_PACKET)) |-> (!loss_detected && (expired_count == '0)))
		else $error("packet result carries sweep fields");
	a_sweep_nokey: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (cmd_q == CMD_SWEEP)) |-> (key_out == '0))
		else $error("sweep result carries a key");
`endif

endmodule

`default_nettype wire
